// File: src/fscu_pkg.sv
// Shared types and constants of the falling-sand cell update block.
// Used by the controller, the datapath and the top level; no dependencies.
package fscu_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned DEF_GRID_CELLS    = 65536;
  localparam int unsigned DEF_MAX_ROW_WIDTH = 1024;

  // Field and register widths
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned CFG_IDX_W  = 1;

  // Register reset values
  localparam logic [ROW_W-1:0]   ROW_WIDTH_RST  = 11'd256;
  localparam logic [COUNT_W-1:0] CELL_COUNT_RST = 17'd65536;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 1'b1;

  // Modes
  localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd2;

  // Cell types
  localparam logic [TYPE_W-1:0] CELL_EMPTY = 2'd0;
  localparam logic [TYPE_W-1:0] CELL_SAND  = 2'd1;
  localparam logic [TYPE_W-1:0] CELL_WATER = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] cell_index;
    logic [TYPE_W-1:0]  cell_type;
    logic               random_bit;
  } in_item_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  read_type;
    logic               moved;
    logic [INDEX_W-1:0] target_index;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_READ_WAIT,
    ST_PROBE,
    ST_PROBE_WAIT,
    ST_WR_SRC,
    ST_WR_TGT,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    ADDR_CLEAR,
    ADDR_ITEM,
    ADDR_PROBE,
    ADDR_TARGET
  } addr_sel_e;

  typedef enum logic [1:0] {
    WD_EMPTY,
    WD_ITEM,
    WD_SOURCE,
    WD_TARGET
  } wd_sel_e;

  typedef struct packed {
    logic      load_item;
    logic      clear_step;
    logic      mem_re;
    logic      mem_we;
    addr_sel_e addr_sel;
    wd_sel_e   wd_sel;
    logic      cap_read;
    logic      cap_move;
    logic      set_moved;
    logic      probe_adv;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              clear_done;
    logic              index_ok;
    logic              update_go;
    logic              probe_blocked;
    logic              probe_ok;
    logic              probe_last;
  } ctrl_sts_t;

endpackage

// File: src/fscu_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module fscu_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/fscu_ctrl.sv
// Sequencer of the falling-sand cell update block.
// Depends on fscu_pkg; drives the datapath through ctrl_cmd_t.
module fscu_ctrl
  import fscu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      out_ready_i,
  input  ctrl_sts_t sts_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.addr_sel = ADDR_ITEM;
    cmd_o.wd_sel   = WD_EMPTY;
    in_ready_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        cmd_o.mem_we     = 1'b1;
        cmd_o.addr_sel   = ADDR_CLEAR;
        cmd_o.wd_sel     = WD_EMPTY;
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_d = ST_RESP;
        case (sts_i.mode)
          MODE_WRITE: begin
            cmd_o.mem_we = sts_i.index_ok;
            cmd_o.wd_sel = WD_ITEM;
          end
          MODE_READ: begin
            if (sts_i.index_ok) begin
              cmd_o.mem_re = 1'b1;
              state_d      = ST_READ_WAIT;
            end
          end
          MODE_UPDATE: begin
            if (sts_i.update_go) begin
              state_d = ST_PROBE;
            end
          end
          default: ;
        endcase
      end
      ST_READ_WAIT: begin
        cmd_o.cap_read = 1'b1;
        state_d        = ST_RESP;
      end
      ST_PROBE: begin
        // skip blocked neighbors without a memory access
        if (sts_i.probe_blocked) begin
          cmd_o.probe_adv = 1'b1;
          if (sts_i.probe_last) begin
            state_d = ST_RESP;
          end
        end else begin
          cmd_o.mem_re   = 1'b1;
          cmd_o.addr_sel = ADDR_PROBE;
          state_d        = ST_PROBE_WAIT;
        end
      end
      ST_PROBE_WAIT: begin
        if (sts_i.probe_ok) begin
          cmd_o.cap_move = 1'b1;
          state_d        = ST_WR_SRC;
        end else begin
          cmd_o.probe_adv = 1'b1;
          state_d         = sts_i.probe_last ? ST_RESP : ST_PROBE;
        end
      end
      ST_WR_SRC: begin
        cmd_o.mem_we   = 1'b1;
        cmd_o.addr_sel = ADDR_ITEM;
        cmd_o.wd_sel   = WD_SOURCE;
        state_d        = ST_WR_TGT;
      end
      ST_WR_TGT: begin
        cmd_o.mem_we    = 1'b1;
        cmd_o.addr_sel  = ADDR_TARGET;
        cmd_o.wd_sel    = WD_TARGET;
        cmd_o.set_moved = 1'b1;
        state_d         = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/fscu_dp.sv
// Datapath of the falling-sand cell update block: registers, neighbor
// index arithmetic and the grid RAM. Depends on fscu_pkg and fscu_ram.
module fscu_dp
  import fscu_pkg::*;
#(
  parameter int unsigned GRID_CELLS    = DEF_GRID_CELLS,
  parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  in_item_t             in_item_i,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_sts_t            sts_o,
  output out_item_t            out_item_o
);

  localparam int unsigned AW    = $clog2(GRID_CELLS);
  localparam int unsigned NW    = $clog2(GRID_CELLS + 1);
  localparam int unsigned CNT_W = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int unsigned IW    = CNT_W + 1;
  localparam int unsigned MW    = $clog2(MAX_ROW_WIDTH + 1);
  localparam int unsigned RW    = (MW > ROW_W) ? MW : ROW_W;

  localparam logic [CNT_W-1:0] GRID_LIM = CNT_W'(GRID_CELLS);
  localparam logic [RW-1:0]    ROW_LIM  = RW'(MAX_ROW_WIDTH);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(GRID_CELLS - 1);

  // probe order
  localparam logic [2:0] PRB_DOWN  = 3'd0;
  localparam logic [2:0] PRB_DIAG1 = 3'd1;
  localparam logic [2:0] PRB_DIAG2 = 3'd2;
  localparam logic [2:0] PRB_SIDE1 = 3'd3;
  localparam logic [2:0] PRB_SIDE2 = 3'd4;

  logic [ROW_W-1:0]   row_q;
  logic [COUNT_W-1:0] cnt_q;
  logic [AW-1:0]      clr_q;
  logic [2:0]         k_q;

  logic [MODE_W-1:0]  mode_q;
  logic [INDEX_W-1:0] idx_q;
  logic [TYPE_W-1:0]  ctype_q;
  logic               rf_q;
  logic [IW-1:0]      below_q;
  logic [IW-1:0]      cand_q;
  logic [TYPE_W-1:0]  other_q;
  logic [TYPE_W-1:0]  read_type_q;
  logic               moved_q;
  out_item_t          out_q;

  logic [RW-1:0]     eff_w;
  logic [CNT_W-1:0]  eff_cnt;
  logic [CNT_W-1:0]  cnt_ext;
  logic [RW-1:0]     row_ext;
  logic [IW-1:0]     idx_ext;
  logic [IW-1:0]     cand;
  logic              is_sand;
  logic [AW-1:0]     mem_addr;
  logic [TYPE_W-1:0] mem_wdata;
  logic [TYPE_W-1:0] mem_rdata;

  assign row_ext = RW'(row_q);
  assign cnt_ext = CNT_W'(cnt_q);
  assign eff_w   = (row_ext > ROW_LIM) ? ROW_LIM : row_ext;
  assign eff_cnt = (cnt_ext > GRID_LIM) ? GRID_LIM : cnt_ext;
  assign idx_ext = IW'(idx_q);
  assign is_sand = (ctype_q == CELL_SAND);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= ROW_WIDTH_RST;
      cnt_q <= CELL_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_WIDTH:  row_q <= cfg_wdata_i[ROW_W-1:0];
        REG_CELL_COUNT: cnt_q <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      k_q   <= PRB_DOWN;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.load_item) begin
        k_q <= PRB_DOWN;
      end else if (cmd_i.probe_adv) begin
        k_q <= k_q + 3'd1;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mode_q      <= in_item_i.mode;
      idx_q       <= in_item_i.cell_index;
      ctype_q     <= in_item_i.cell_type;
      rf_q        <= in_item_i.random_bit;
      below_q     <= IW'(in_item_i.cell_index) + IW'(eff_w);
      read_type_q <= CELL_EMPTY;
      moved_q     <= 1'b0;
    end
    if (cmd_i.cap_read) begin
      read_type_q <= mem_rdata;
    end
    if (cmd_i.cap_move) begin
      cand_q  <= cand;
      other_q <= mem_rdata;
    end
    if (cmd_i.set_moved) begin
      moved_q <= 1'b1;
    end
    if (cmd_i.out_load) begin
      out_q.read_type    <= read_type_q;
      out_q.moved        <= moved_q;
      out_q.target_index <= moved_q ? cand_q[INDEX_W-1:0] : '0;
    end
  end

  // neighbor index for the current probe step
  always_comb begin
    case (k_q)
      PRB_DOWN:  cand = below_q;
      PRB_DIAG1: cand = rf_q ? below_q + IW'(1) : below_q - IW'(1);
      PRB_DIAG2: cand = rf_q ? below_q - IW'(1) : below_q + IW'(1);
      PRB_SIDE1: cand = rf_q ? idx_ext + IW'(1) : idx_ext - IW'(1);
      PRB_SIDE2: cand = rf_q ? idx_ext - IW'(1) : idx_ext + IW'(1);
      default:   cand = below_q;
    endcase
  end

  always_comb begin
    case (cmd_i.addr_sel)
      ADDR_CLEAR:  mem_addr = clr_q;
      ADDR_ITEM:   mem_addr = idx_ext[AW-1:0];
      ADDR_PROBE:  mem_addr = cand[AW-1:0];
      ADDR_TARGET: mem_addr = cand_q[AW-1:0];
      default:     mem_addr = idx_ext[AW-1:0];
    endcase
  end

  always_comb begin
    case (cmd_i.wd_sel)
      WD_EMPTY:  mem_wdata = CELL_EMPTY;
      WD_ITEM:   mem_wdata = (ctype_q inside {CELL_SAND, CELL_WATER}) ? ctype_q : CELL_EMPTY;
      WD_SOURCE: mem_wdata = is_sand ? other_q : CELL_EMPTY;
      WD_TARGET: mem_wdata = is_sand ? CELL_SAND : CELL_WATER;
      default:   mem_wdata = CELL_EMPTY;
    endcase
  end

  fscu_ram #(
    .WIDTH (TYPE_W),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mem_we),
    .re_i    (cmd_i.mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign sts_o.mode          = mode_q;
  assign sts_o.clear_done    = (clr_q == LAST_ADDR);
  assign sts_o.index_ok      = (idx_ext[CNT_W-1:0] < GRID_LIM);
  assign sts_o.update_go     = (ctype_q inside {CELL_SAND, CELL_WATER}) &&
                               ((below_q + IW'(1)) < {1'b0, eff_cnt});
  assign sts_o.probe_blocked = cand[IW-1] || (cand[IW-2:0] >= eff_cnt);
  assign sts_o.probe_ok      = is_sand ? (mem_rdata == CELL_EMPTY || mem_rdata == CELL_WATER)
                                       : (mem_rdata == CELL_EMPTY);
  assign sts_o.probe_last    = is_sand ? (k_q == PRB_DIAG2) : (k_q == PRB_SIDE2);

  assign out_item_o = out_q;

endmodule

// File: src/falling_sand_cell_update.sv
// Top level of the falling-sand cell update block.
// Depends on fscu_pkg, fscu_ctrl, fscu_dp (which holds fscu_ram).
//
//   channel  signals                       direction  payload
//   input    in_valid_i / in_ready_o       in         in_item_i  (in_item_t)
//   output   out_valid_o / out_ready_i     out        out_item_o (out_item_t)
//   config   cfg_we_i, cfg_idx_i           in         cfg_wdata_i (write only)
//
// One transaction at a time. A write or an out-of-range read goes from
// acceptance through dispatch to the result register, a read also waits
// for the RAM data, and an update walks its neighbors: each neighbor inside
// the grid costs one access of the single-port grid RAM plus a wait state to
// inspect its data, one outside is skipped, and a move adds two writes.
// After reset the grid RAM is cleared one cell per cycle, with in_ready_o low;
// config writes are taken throughout.
// A finished result waits in the output register while the next transaction
// is accepted and worked on; that one holds in its last step until the
// register frees up.
module falling_sand_cell_update
  import fscu_pkg::*;
#(
  parameter int unsigned GRID_CELLS    = DEF_GRID_CELLS,
  parameter int unsigned MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // sequencer: clear pass, dispatch by mode, probe walk, write-back
  fscu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // datapath: config registers, neighbor indexes, grid RAM, result register
  fscu_dp #(
    .GRID_CELLS    (GRID_CELLS),
    .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

endmodule
